>>> sv/coordinate_rank_compressor_defines.svh
// assertion macros used by the checker file
`ifndef COORDINATE_RANK_COMPRESSOR_DEFINES_SVH
`define COORDINATE_RANK_COMPRESSOR_DEFINES_SVH

// property checked on every rising edge outside reset
`define CRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked on every rising edge, reset included
`define CRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/crc_pkg.sv
// shared types, sizes and the to_key helper function of the coordinate rank compressor
package crc_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    // input item
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               block_end;
    } in_t;

    // result item
    typedef struct packed {
        logic [5:0] rank;
        logic [6:0] distinct_count;
        logic       truncated;
        logic       run_end;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        idx_t rd_addr;
        logic rank_load;
        logic last;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        cnt_t item_count;
    } stat_t;

    // sign-extend the sample, keep the low VALUE_BITS bits
    function automatic value_t to_key(input logic [31:0] raw);
        logic [63:0] ext;
        ext = {{32{raw[31]}}, raw};
        return value_t'(ext[VALUE_BITS-1:0]);
    endfunction

endpackage

>>> sv/crc_ctrl.sv
// controller: load phase and result sequencing
module crc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_block_end,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  crc_pkg::stat_t   stat,
    output crc_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RANK,
        ST_SEND
    } state_t;

    state_t        state_reg, state_next;
    crc_pkg::idx_t idx_reg, idx_next;
    logic          is_last;

    // current result is the last stored element
    assign is_last = ((crc_pkg::CNT_W'(idx_reg) + crc_pkg::CNT_W'(1)) == stat.item_count);

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.load      = 1'b0;
        cmd.rd_addr   = idx_reg;
        cmd.rank_load = 1'b0;
        cmd.last      = is_last;
        cmd.clear     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_block_end) begin
                        idx_next   = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_RANK;
            end
            ST_RANK: begin
                cmd.rank_load = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND: begin
                m_valid = 1'b1;
                // prefetch the next stored element while the result waits
                cmd.rd_addr = idx_reg + crc_pkg::IDX_W'(1);
                if (m_ready) begin
                    if (is_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + crc_pkg::IDX_W'(1);
                        state_next = ST_RANK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> sv/crc_datapath.sv
// datapath: arrival memory, sorted distinct table, rank encoder, output register
module crc_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  crc_pkg::in_t    s_data,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    input  crc_pkg::cmd_t   cmd,
    output crc_pkg::stat_t  stat,
    output crc_pkg::out_t   m_data
);

    crc_pkg::value_t arr_mem [crc_pkg::MAX_ITEMS];
    crc_pkg::value_t tbl_reg [crc_pkg::MAX_ITEMS];
    crc_pkg::value_t tbl_next [crc_pkg::MAX_ITEMS];
    crc_pkg::value_t rd_q_reg;
    crc_pkg::value_t key;
    crc_pkg::cnt_t   item_count_reg, item_count_next;
    crc_pkg::cnt_t   unique_count_reg, unique_count_next;
    logic            overflow_reg, overflow_next;
    logic            desc_reg;
    logic            has_room;
    logic            found;
    logic [crc_pkg::MAX_ITEMS-1:0] ins_lt;
    logic [crc_pkg::MAX_ITEMS-1:0] rank_lt;
    crc_pkg::idx_t   asc_rank;
    crc_pkg::idx_t   final_rank;
    crc_pkg::out_t   out_reg;

    assign key      = crc_pkg::to_key(s_data.sample_value);
    assign has_room = (item_count_reg < crc_pkg::CNT_W'(crc_pkg::MAX_ITEMS));
    assign stat.item_count = item_count_reg;
    assign m_data   = out_reg;

    // per-cell compare against the incoming key, shifting insert
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < crc_pkg::MAX_ITEMS; i++) begin
            ins_lt[i] = (crc_pkg::CNT_W'(i) < unique_count_reg) && (tbl_reg[i] < key);
            if ((crc_pkg::CNT_W'(i) < unique_count_reg) && (tbl_reg[i] == key)) begin
                found = 1'b1;
            end
        end
        for (int i = 0; i < crc_pkg::MAX_ITEMS; i++) begin
            if (ins_lt[i]) begin
                tbl_next[i] = tbl_reg[i];
            end else if (i == 0) begin
                tbl_next[i] = key;
            end else if (ins_lt[(i > 0) ? i - 1 : 0]) begin
                tbl_next[i] = key;
            end else begin
                tbl_next[i] = tbl_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // counters and overflow flag
    always_comb begin
        item_count_next   = item_count_reg;
        unique_count_next = unique_count_reg;
        overflow_next     = overflow_reg;
        if (cmd.clear) begin
            item_count_next   = '0;
            unique_count_next = '0;
            overflow_next     = 1'b0;
        end else if (cmd.load) begin
            if (has_room) begin
                item_count_next = item_count_reg + crc_pkg::CNT_W'(1);
                if (!found) begin
                    unique_count_next = unique_count_reg + crc_pkg::CNT_W'(1);
                end
            end else begin
                overflow_next = 1'b1;
            end
        end
    end

    // rank of the fetched element: the table is sorted, so the less-than
    // vector is a thermometer and the rank is where it ends
    always_comb begin
        asc_rank = '0;
        for (int i = 0; i < crc_pkg::MAX_ITEMS; i++) begin
            rank_lt[i] = (crc_pkg::CNT_W'(i) < unique_count_reg) && (tbl_reg[i] < rd_q_reg);
        end
        for (int i = 0; i < crc_pkg::MAX_ITEMS; i++) begin
            if (i == 0) begin
                if (!rank_lt[0]) begin
                    asc_rank = asc_rank | crc_pkg::IDX_W'(i);
                end
            end else if (rank_lt[(i > 0) ? i - 1 : 0] && !rank_lt[i]) begin
                asc_rank = asc_rank | crc_pkg::IDX_W'(i);
            end
        end
        if (desc_reg) begin
            final_rank = crc_pkg::IDX_W'(unique_count_reg - crc_pkg::CNT_W'(1)) - asc_rank;
        end else begin
            final_rank = asc_rank;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg   <= '0;
            unique_count_reg <= '0;
            overflow_reg     <= 1'b0;
            desc_reg         <= 1'b0;
        end else begin
            item_count_reg   <= item_count_next;
            unique_count_reg <= unique_count_next;
            overflow_reg     <= overflow_next;
            if (cfg_valid) begin
                desc_reg <= cfg_data;
            end
        end
    end

    // arrival memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && has_room) begin
            arr_mem[item_count_reg[crc_pkg::IDX_W-1:0]] <= key;
        end
        rd_q_reg <= arr_mem[cmd.rd_addr];
    end

    // sorted table cells
    always_ff @(posedge aclk) begin
        if (cmd.load && has_room && !found) begin
            for (int i = 0; i < crc_pkg::MAX_ITEMS; i++) begin
                tbl_reg[i] <= tbl_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.rank_load) begin
            out_reg.rank           <= 6'(final_rank);
            out_reg.distinct_count <= 7'(unique_count_reg);
            out_reg.truncated      <= overflow_reg;
            out_reg.run_end        <= cmd.last;
        end
    end

endmodule

>>> sv/coordinate_rank_compressor.sv
// Coordinate rank compressor, top level. Elements of a block are taken one
// per cycle until the element flagged block_end; up to 64 are kept, further
// ones are dropped and reported through truncated. After the last element
// the input stalls and one result per stored element comes out in arrival
// order. Each is read through the single read port of the arrival memory,
// ranked against the sorted table into the result register and held while
// m_ready is low. The input reopens once the last result transfers. The
// descending register is written through the cfg channel, which is always
// ready, and is used when the ranks are formed.
module coordinate_rank_compressor (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  crc_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output crc_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    crc_pkg::cmd_t  cmd;
    crc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencing
    crc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_block_end (s_data.block_end),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // storage and ranking
    crc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

>>> sv/crc_checker.sv
// port-level checker for the coordinate rank compressor, with its bind
`include "coordinate_rank_compressor_defines.svh"

module crc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input crc_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input crc_pkg::out_t m_data,
    input logic          cfg_ready
);

    // input is closed while results are being delivered
    `CRC_ASSERT(a_no_input_while_out, aclk, aresetn, m_valid |-> !s_ready, "input open during output")

    // a block end transfer closes the input on the next cycle
    `CRC_ASSERT(a_end_closes_input, aclk, aresetn, (s_valid && s_ready && s_data.block_end) |=> !s_ready, "input open after block end")

    // every rank lies below the distinct count
    `CRC_ASSERT(a_rank_range, aclk, aresetn, m_valid |-> ({1'b0, m_data.rank} < m_data.distinct_count), "rank out of range")

    // a stalled result holds
    `CRC_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result changed while stalled")

    // configuration channel never stalls
    `CRC_ASSERT_ALWAYS(a_cfg_ready, aclk, cfg_ready, "cfg channel not ready")

endmodule

bind coordinate_rank_compressor crc_checker u_crc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
